/* rtl/core/next_greater_element_stack_unit_defines.svh */
// Assertion macros shared by the next-greater-element stack unit.
// Define ASSERT_OFF to compile every check away.
`ifndef NEXT_GREATER_ELEMENT_STACK_UNIT_DEFINES_SVH
`define NEXT_GREATER_ELEMENT_STACK_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define NGS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ngs: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define NGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ngs: next-cycle check failed");
`else
`define NGS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/ngs_pkg.sv */
package ngs_pkg;

   localparam int STACK_DEPTH    = 64;
   localparam int INDEX_BITS     = 16;
   localparam int VALUE_BITS     = 32;
   localparam int OUT_INDEX_BITS = 16;
   localparam int STATUS_BITS    = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_BITS-1:0] STAT_FOUND    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_NONE     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW = 2'd2;

   localparam logic signed [VALUE_BITS-1:0] NO_GREATER = '1;

   // One classified request as it travels from the front end to the back end.
   typedef struct packed {
      logic                         is_end;
      logic signed [VALUE_BITS-1:0] value;
      logic [INDEX_BITS-1:0]        idx;
   } item_type;

   // One stack entry.
   typedef struct packed {
      logic [INDEX_BITS-1:0]        idx;
      logic signed [VALUE_BITS-1:0] value;
   } entry_type;

   // One result waiting for its last flag.
   typedef struct packed {
      logic [STATUS_BITS-1:0]       status;
      logic [INDEX_BITS-1:0]        idx;
      logic signed [VALUE_BITS-1:0] value;
      logic signed [VALUE_BITS-1:0] greater;
   } result_type;

endpackage

/* rtl/core/next_greater_element_stack_unit.sv */
// Next-greater-element unit. Each request is either an element (req_type 0) or
// an end of sequence (req_type 1). An element resolves every pending element
// whose value is strictly smaller, newest first, one result per resolved
// element with status "found", and then becomes pending itself; equal values
// stay pending. End of sequence reports every pending element as "no greater"
// (greater_value -1), newest first, and restarts numbering at zero. When 64
// elements are pending and a new one resolves none of them, the new element is
// dropped and reported with status "overflow"; its index is still consumed.
// rsp_last marks the final result of a request; a request that causes no
// result produces nothing on the response channel. Timing: the front end
// takes a request in any cycle the two-entry queue has room. The back end
// picks up a request in its idle state and decides it in its evaluate state;
// each resolved entry then passes through a fetch state that reads the next
// entry from the stack memory, except after the pop that empties the stack.
// Each element is popped at most once. A stalled response channel holds the
// back end in its evaluate state while a result waits. The stack memory needs
// no clearing after reset.
module next_greater_element_stack_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_element_index,
   output logic signed [31:0] rsp_element_value,
   output logic signed [31:0] rsp_greater_value,
   output logic               rsp_last
);

   // Front end to queue: classified request with its element index.
   logic              q_push;
   logic              q_full;
   ngs_pkg::item_type q_in_item;

   // Queue to back end.
   logic              q_not_empty;
   logic              q_pop;
   ngs_pkg::item_type q_out_item;

   // Accept requests and number elements.
   ngs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   // Decouple request intake from stack work.
   ngs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_out_item)
   );

   // Run the monotonic stack and drive the response register.
   ngs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_not_empty),
      .q_item            (q_out_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_element_index (rsp_element_index),
      .rsp_element_value (rsp_element_value),
      .rsp_greater_value (rsp_greater_value),
      .rsp_last          (rsp_last)
   );

endmodule

/* rtl/core/ngs_front.sv */
module ngs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic signed [31:0]  req_value,
   input  logic                q_full,
   output logic                q_push,
   output ngs_pkg::item_type   q_item
);

   logic [ngs_pkg::INDEX_BITS-1:0] pos_ff;
   logic [ngs_pkg::INDEX_BITS-1:0] pos_in;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign q_item.is_end = req_type;
   assign q_item.value  = req_value;
   assign q_item.idx    = pos_ff;

   // Restart numbering on end of sequence, advance (and wrap) on elements.
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (req_type) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/core/ngs_queue.sv */
module ngs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ngs_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ngs_pkg::item_type pop_item
);

   localparam logic [ngs_pkg::QPTR_BITS-1:0]   PtrLast =
      ngs_pkg::QPTR_BITS'(ngs_pkg::QUEUE_DEPTH - 1);
   localparam logic [ngs_pkg::QCOUNT_BITS-1:0] CountFull =
      ngs_pkg::QCOUNT_BITS'(ngs_pkg::QUEUE_DEPTH);

   ngs_pkg::item_type slot_ff [ngs_pkg::QUEUE_DEPTH];

   logic [ngs_pkg::QPTR_BITS-1:0]   wr_ptr_ff;
   logic [ngs_pkg::QPTR_BITS-1:0]   wr_ptr_in;
   logic [ngs_pkg::QPTR_BITS-1:0]   rd_ptr_ff;
   logic [ngs_pkg::QPTR_BITS-1:0]   rd_ptr_in;
   logic [ngs_pkg::QCOUNT_BITS-1:0] count_ff;
   logic [ngs_pkg::QCOUNT_BITS-1:0] count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full      = (count_ff == CountFull);
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/ngs_back.sv */
`include "next_greater_element_stack_unit_defines.svh"

module ngs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ngs_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_element_index,
   output logic signed [31:0]  rsp_element_value,
   output logic signed [31:0]  rsp_greater_value,
   output logic                rsp_last
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;

   localparam logic [ngs_pkg::COUNT_BITS-1:0] CountFull =
      ngs_pkg::COUNT_BITS'(ngs_pkg::STACK_DEPTH);

   ngs_pkg::entry_type mem [ngs_pkg::STACK_DEPTH];

   logic [1:0]                      state_ff;
   logic [1:0]                      state_in;
   logic [ngs_pkg::COUNT_BITS-1:0]  count_ff;
   logic [ngs_pkg::COUNT_BITS-1:0]  count_in;
   logic [ngs_pkg::COUNT_BITS-1:0]  count_dec;
   logic [ngs_pkg::COUNT_BITS-1:0]  count_dec2;
   ngs_pkg::item_type               cur_ff;
   ngs_pkg::entry_type              top_ff;
   ngs_pkg::entry_type              mem_rd_ff;
   logic                            pend_valid_ff;
   logic                            pend_valid_in;
   ngs_pkg::result_type             pend_ff;
   ngs_pkg::result_type             pend_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ngs_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [ngs_pkg::INDEX_BITS-1:0]  rsp_idx_ff;
   logic signed [31:0]              rsp_value_ff;
   logic signed [31:0]              rsp_greater_ff;
   logic                            rsp_last_ff;

   logic top_valid;
   logic pops;
   logic stack_full;
   logic overflow;
   logic push_now;
   logic need_out;
   logic out_free;
   logic go;
   logic load_out;
   logic rd_en;
   logic ovf_shown;

   assign count_dec  = count_ff - 1'b1;
   assign count_dec2 = count_ff - 2'd2;

   // Decide the step for the item under evaluation.
   assign top_valid  = (count_ff != '0);
   assign pops       = top_valid && (cur_ff.is_end || (top_ff.value < cur_ff.value));
   assign stack_full = (count_ff == CountFull);
   assign overflow   = !pops && !cur_ff.is_end && stack_full;
   assign push_now   = !pops && !cur_ff.is_end && !stack_full;
   assign need_out   = pend_valid_ff || overflow;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign go         = (state_ff == S_EVAL) && (!need_out || out_free);
   assign load_out   = go && need_out;
   assign rd_en      = go && pops && (count_ff > ngs_pkg::COUNT_BITS'(1));

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (go) begin
               pend_valid_in = pops;
               if (pops) begin
                  // Hold the popped entry until the next step tells its last flag.
                  pend_in.status  = cur_ff.is_end ? ngs_pkg::STAT_NONE : ngs_pkg::STAT_FOUND;
                  pend_in.idx     = top_ff.idx;
                  pend_in.value   = top_ff.value;
                  pend_in.greater = cur_ff.is_end ? ngs_pkg::NO_GREATER : cur_ff.value;
                  count_in        = count_dec;
                  state_in        = rd_en ? S_FETCH : S_EVAL;
               end else begin
                  if (push_now) begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_FETCH: begin
            state_in = S_EVAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (go && push_now) begin
         top_ff.idx   <= cur_ff.idx;
         top_ff.value <= cur_ff.value;
      end else if (state_ff == S_FETCH) begin
         top_ff <= mem_rd_ff;
      end
      if (load_out) begin
         if (pend_valid_ff) begin
            rsp_status_ff  <= pend_ff.status;
            rsp_idx_ff     <= pend_ff.idx;
            rsp_value_ff   <= pend_ff.value;
            rsp_greater_ff <= pend_ff.greater;
            rsp_last_ff    <= !pops;
         end else begin
            rsp_status_ff  <= ngs_pkg::STAT_OVERFLOW;
            rsp_idx_ff     <= cur_ff.idx;
            rsp_value_ff   <= cur_ff.value;
            rsp_greater_ff <= ngs_pkg::NO_GREATER;
            rsp_last_ff    <= 1'b1;
         end
      end
   end

   // Stack memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (go && push_now) begin
         mem[count_ff[ngs_pkg::ADDR_BITS-1:0]] <= '{idx: cur_ff.idx, value: cur_ff.value};
      end
      if (rd_en) begin
         mem_rd_ff <= mem[count_dec2[ngs_pkg::ADDR_BITS-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_index = ngs_pkg::OUT_INDEX_BITS'(rsp_idx_ff);
   assign rsp_element_value = rsp_value_ff;
   assign rsp_greater_value = rsp_greater_ff;
   assign rsp_last          = rsp_last_ff;

   assign ovf_shown = rsp_valid_ff && rsp_last_ff && (rsp_status_ff == ngs_pkg::STAT_OVERFLOW);

   `NGS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CountFull)
   `NGS_ASSERT_IMPLY(a_idle_no_pend, clock, reset, state_ff == S_IDLE, !pend_valid_ff)
   `NGS_ASSERT_IMPLY(a_fetch_nonempty, clock, reset, state_ff == S_FETCH, count_ff != '0)
   `NGS_ASSERT_NEXT(a_ovf_last, clock, reset, go && overflow, ovf_shown)

endmodule
